// ===== design/mpeg_audio_frame_length_unit_defines.svh =====
// Assertion macros for the frame length unit's checker.
`ifndef MPEG_AUDIO_FRAME_LENGTH_UNIT_DEFINES_SVH
`define MPEG_AUDIO_FRAME_LENGTH_UNIT_DEFINES_SVH

// Property checked at each rising clock edge, switched off while in reset.
`define MPAL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked at every rising clock edge, reset included.
`define MPAL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== design/mpal_pkg.sv =====
// Types, header field codes and lookup tables for the frame length unit.
package mpal_pkg;

  // Version field codes
  localparam logic [1:0] VER_MPEG25 = 2'b00;
  localparam logic [1:0] VER_RSVD   = 2'b01;
  localparam logic [1:0] VER_MPEG2  = 2'b10;
  localparam logic [1:0] VER_MPEG1  = 2'b11;

  // Layer field codes
  localparam logic [1:0] LAYER_RSVD = 2'b00;
  localparam logic [1:0] LAYER_3    = 2'b01;
  localparam logic [1:0] LAYER_2    = 2'b10;
  localparam logic [1:0] LAYER_1    = 2'b11;

  // Sample-rate index codes
  localparam logic [1:0] SR_44K1 = 2'd0;
  localparam logic [1:0] SR_48K  = 2'd1;
  localparam logic [1:0] SR_32K  = 2'd2;
  localparam logic [1:0] SR_RSVD = 2'd3;

  // Bitrate index codes that carry no table entry
  localparam logic [3:0] BR_FREE = 4'd0;
  localparam logic [3:0] BR_BAD  = 4'd15;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [2:0] SYNC_BITS = 3'b111;

  // Samples-per-frame factors
  localparam logic [7:0] K_LAYER1 = 8'd12;
  localparam logic [7:0] K_HALF   = 8'd72;
  localparam logic [7:0] K_FULL   = 8'd144;

  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned QUOT_W      = 12;
  localparam int unsigned NUM_W       = 20;
  localparam int unsigned REM_W       = 10;
  localparam int unsigned M_W         = 17;
  localparam int unsigned RECIP_W     = 31;

  // Divisor applied after scaling: 44.1 kHz family, 48 kHz family, 32 kHz family
  typedef enum logic [1:0] {
    DIV_441 = 2'd0,
    DIV_3   = 2'd1,
    DIV_1   = 2'd2
  } div_cls_e;

  // Bitrates in kbit/s
  localparam logic [8:0] KBPS_V1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
    9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] KBPS_V1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] KBPS_V1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
    9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] KBPS_V2_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] KBPS_V2_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
    9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  function automatic logic [8:0] kbps_lookup(logic mpeg1, logic [1:0] layer,
                                             logic [3:0] idx);
    logic [8:0] kbps;
    kbps = '0;
    if (mpeg1) begin
      case (layer)
        LAYER_1: kbps = KBPS_V1_L1[idx];
        LAYER_2: kbps = KBPS_V1_L2[idx];
        default: kbps = KBPS_V1_L3[idx];
      endcase
    end else begin
      case (layer)
        LAYER_1: kbps = KBPS_V2_L1[idx];
        default: kbps = KBPS_V2_L23[idx];
      endcase
    end
    return kbps;
  endfunction

  function automatic logic [8:0] div_value(div_cls_e cls);
    logic [8:0] d;
    case (cls)
      DIV_441: d = 9'd441;
      DIV_3:   d = 9'd3;
      default: d = 9'd1;
    endcase
    return d;
  endfunction

  // 2^32 / divisor rounded to nearest; the divide-by-one class bypasses the multiplier
  function automatic logic [RECIP_W-1:0] div_recip(div_cls_e cls);
    logic [RECIP_W-1:0] r;
    case (cls)
      DIV_441: r = 31'd9739155;
      DIV_3:   r = 31'd1431655765;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/mpeg_audio_frame_length_unit.sv =====
// MPEG audio frame header check and frame length, four-stage pipeline.
//
// Takes three header bytes a cycle and returns the frame length in bytes, or 0
// with header_ok_o low for a bad or incomplete header. One item enters per
// cycle while in_stall_o is low and passes the stage 1, 2, 3 and 4 registers
// in order. Stage 1 decodes and validates the header and forms k * kbps scaled
// for the sample-rate halving or quartering; stage 2 folds the 1000/rate
// factor into a small divisor (441, 3 or 1) and multiplies by its reciprocal
// unless it is 1; stage 3 forms the remainder; stage 4 applies the one-step
// correction and padding. Each stage holds its item while the stage after it
// is full and stalled, so bubbles close up and nothing is lost or repeated.
module mpeg_audio_frame_length_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] header_word_i,
  input  logic        header_complete_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] frame_length_o,
  output logic        header_ok_o
);
  import mpal_pkg::*;

  // Stage valid bits and advance enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------- Stage 1: decode, validate, k * kbps ----------------
  logic [7:0] b0, b1, b2;
  logic [1:0] version, layer, sr_idx;
  logic [3:0] br_idx;
  logic       pad;
  logic       ok1_d;
  logic [8:0] kbps;
  logic [7:0] k;
  logic [1:0] s;
  logic [M_W-1:0] kb_prod;
  logic [M_W-1:0] m1_d;
  div_cls_e   cls1_d;

  assign b0      = header_word_i[23:16];
  assign b1      = header_word_i[15:8];
  assign b2      = header_word_i[7:0];
  assign version = b1[4:3];
  assign layer   = b1[2:1];
  assign br_idx  = b2[7:4];
  assign sr_idx  = b2[3:2];
  assign pad     = b2[1];

  assign ok1_d = header_complete_i && (b0 == SYNC_BYTE) && (b1[7:5] == SYNC_BITS) &&
                 (version != VER_RSVD) && (layer != LAYER_RSVD) &&
                 (br_idx != BR_FREE) && (br_idx != BR_BAD) && (sr_idx != SR_RSVD);

  assign kbps = kbps_lookup(version == VER_MPEG1, layer, br_idx);

  always_comb begin
    // samples factor
    if (layer == LAYER_1) begin
      k = K_LAYER1;
    end else if (layer == LAYER_3 && version != VER_MPEG1) begin
      k = K_HALF;
    end else begin
      k = K_FULL;
    end
    // sample-rate halving or quartering folded into the numerator
    case (version)
      VER_MPEG1: s = 2'd0;
      VER_MPEG2: s = 2'd1;
      default:   s = 2'd2;
    endcase
    // divisor class per base sample rate
    case (sr_idx)
      SR_44K1: cls1_d = DIV_441;
      SR_48K:  cls1_d = DIV_3;
      default: cls1_d = DIV_1;
    endcase
  end

  assign kb_prod = M_W'(k) * M_W'(kbps);
  assign m1_d    = kb_prod << s;

  logic           ok1_q, pad1_q, l1_1_q;
  logic [M_W-1:0] m1_q;
  div_cls_e       cls1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ok1_q  <= ok1_d;
      pad1_q <= pad;
      l1_1_q <= (layer == LAYER_1);
      m1_q   <= m1_d;
      cls1_q <= cls1_d;
    end
  end

  // ---------------- Stage 2: scale and reciprocal multiply ----------------
  logic [NUM_W-1:0]         x2_d;
  logic [NUM_W+RECIP_W-1:0] prod2;
  logic [QUOT_W-1:0]        q2_d;

  always_comb begin
    case (cls1_q)
      DIV_441: x2_d = (NUM_W'(m1_q) << 3) + (NUM_W'(m1_q) << 1);
      DIV_3:   x2_d = NUM_W'(m1_q >> 4);
      default: x2_d = NUM_W'(m1_q >> 5);
    endcase
  end

  assign prod2 = (NUM_W+RECIP_W)'(x2_d) * (NUM_W+RECIP_W)'(div_recip(cls1_q));
  assign q2_d  = (cls1_q == DIV_1) ? x2_d[QUOT_W-1:0]
                                   : prod2[RECIP_SHIFT +: QUOT_W];

  logic              ok2_q, pad2_q, l1_2_q;
  logic [NUM_W-1:0]  x2_q;
  logic [QUOT_W-1:0] q2_q;
  div_cls_e          cls2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      ok2_q  <= ok1_q;
      pad2_q <= pad1_q;
      l1_2_q <= l1_1_q;
      x2_q   <= x2_d;
      q2_q   <= q2_d;
      cls2_q <= cls1_q;
    end
  end

  // ---------------- Stage 3: remainder ----------------
  logic [NUM_W-1:0] qd3;
  logic [NUM_W-1:0] r3_full;

  assign qd3     = NUM_W'(q2_q) * NUM_W'(div_value(cls2_q));
  assign r3_full = x2_q - qd3;

  logic              ok3_q, pad3_q, l1_3_q;
  logic [QUOT_W-1:0] q3_q;
  logic [REM_W-1:0]  r3_q;
  div_cls_e          cls3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      ok3_q  <= ok2_q;
      pad3_q <= pad2_q;
      l1_3_q <= l1_2_q;
      q3_q   <= q2_q;
      r3_q   <= r3_full[REM_W-1:0];
      cls3_q <= cls2_q;
    end
  end

  // ---------------- Stage 4: correction, padding, output ----------------
  logic [QUOT_W-1:0] q4;
  logic [QUOT_W-1:0] sum4;
  logic [QUOT_W-1:0] len4_d;

  assign q4   = q3_q + QUOT_W'(r3_q >= REM_W'(div_value(cls3_q)));
  assign sum4 = q4 + QUOT_W'(pad3_q);

  always_comb begin
    if (!ok3_q) begin
      len4_d = '0;
    end else if (l1_3_q) begin
      len4_d = {sum4[QUOT_W-3:0], 2'b00};
    end else begin
      len4_d = sum4;
    end
  end

  logic [QUOT_W-1:0] len4_q;
  logic              ok4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      len4_q <= len4_d;
      ok4_q  <= ok3_q;
    end
  end

  assign out_valid_o    = v4_q;
  assign frame_length_o = len4_q;
  assign header_ok_o    = ok4_q;

endmodule

// ===== design/mpal_checker.sv =====
// Port-level checker for the frame length unit and its bind.
`include "mpeg_audio_frame_length_unit_defines.svh"

module mpal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [23:0] header_word_i,
  input logic        header_complete_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] frame_length_o,
  input logic        header_ok_o
);

  // Port views used by the properties
  logic        bad_out, good_out, len_zero, len_legal, out_held, in_held;
  logic [12:0] out_word;
  logic [24:0] in_word;

  assign bad_out   = out_valid_o && !header_ok_o;
  assign good_out  = out_valid_o && header_ok_o;
  assign len_zero  = (frame_length_o == 12'd0);
  assign len_legal = (frame_length_o >= 12'd24) && (frame_length_o <= 12'd2881);
  assign out_held  = out_valid_o && out_stall_i;
  assign in_held   = in_valid_i && in_stall_o;
  assign out_word  = {frame_length_o, header_ok_o};
  assign in_word   = {header_word_i, header_complete_i};

  // No result is shown while in reset
  `MPAL_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_o, "valid in reset")

  // A rejected header reports zero length
  `MPAL_ASSERT(a_bad_len_zero, clk_i, rst_ni, bad_out |-> len_zero, "bad header, nonzero length")

  // A good header gives a length inside the legal span
  `MPAL_ASSERT(a_good_len_range, clk_i, rst_ni, good_out |-> len_legal, "length out of range")

  // A stalled result holds
  `MPAL_ASSERT(a_out_hold, clk_i, rst_ni, out_held |=> (out_valid_o && $stable(out_word)), "result moved")

  // A stalled input item holds
  `MPAL_ASSERT(a_in_hold, clk_i, rst_ni, in_held |=> (in_valid_i && $stable(in_word)), "item moved")

endmodule

bind mpeg_audio_frame_length_unit mpal_checker u_mpal_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .header_word_i     (header_word_i),
  .header_complete_i (header_complete_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .frame_length_o    (frame_length_o),
  .header_ok_o       (header_ok_o)
);
